[sv/gplp_pkg.sv]
// ----------------------------------------------------------------------------
// gplp_pkg
// Shared types, widths and constants for the position line parser: parse
// phases, status codes, the snapshot control group and a power-of-ten table.
// ----------------------------------------------------------------------------
package gplp_pkg;

    // Default values of the top-level parameters.
    localparam int RESP_LIMIT_DEF  = 511;
    localparam int LINE_LIMIT_DEF  = 160;
    localparam int FRAC_DIGITS_DEF = 6;

    // Fixed widths of the accumulators and results.
    localparam int IP_W      = 17;   // coordinate integer part, up to 99999
    localparam int ALT_W     = 24;   // altitude magnitude in tenths
    localparam int ALT_OUT_W = 25;   // signed altitude result
    localparam int COORD_W   = 35;   // signed coordinate result
    localparam int E7_W      = 24;   // values up to 1e7

    // Parse phases of one response.
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_LEAD,
        PH_FIELDS,
        PH_COUNT,
        PH_DONE,
        PH_DEAD
    } phase_t;

    // Scan state of the number inside the current field.
    typedef enum logic [1:0] {
        NUM_IDLE,
        NUM_INT,
        NUM_FRAC,
        NUM_END
    } num_phase_t;

    // Result status codes.
    typedef logic [2:0] status_t;
    localparam status_t STAT_OK          = 3'd0;
    localparam status_t STAT_NO_HEADER   = 3'd1;
    localparam status_t STAT_LINE_LONG   = 3'd2;
    localparam status_t STAT_NO_FIX      = 3'd3;
    localparam status_t STAT_FEW_FIELDS  = 3'd4;
    localparam status_t STAT_EMPTY_COORD = 3'd5;
    localparam status_t STAT_OVERLONG    = 3'd6;

    // Control group that goes with a finished response.
    typedef struct packed {
        status_t    status;
        logic [1:0] neg;
        logic       alt_present;
        logic       alt_minus;
    } snap_ctrl_t;

    // Powers of ten from 1 to 1e7.
    function automatic logic [E7_W-1:0] pow10(input logic [2:0] n);
        case (n)
            3'd0:    return 24'd1;
            3'd1:    return 24'd10;
            3'd2:    return 24'd100;
            3'd3:    return 24'd1000;
            3'd4:    return 24'd10000;
            3'd5:    return 24'd100000;
            3'd6:    return 24'd1000000;
            3'd7:    return 24'd10000000;
            default: return 24'd1;
        endcase
    endfunction

endpackage

[sv/gplp_scanner.sv]
// ----------------------------------------------------------------------------
// gplp_scanner
// Byte-level scanner: finds the header, tracks the line, splits fields and
// accumulates coordinates and altitude. On the last byte of a response it
// presents a snapshot of the finished state and clears itself.
// ----------------------------------------------------------------------------
module gplp_scanner
    import gplp_pkg::*;
#(
    parameter int RESP_LIMIT  = RESP_LIMIT_DEF,
    parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    localparam int FP_W       = $clog2(10 ** FRAC_DIGITS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 rx_byte,
    input  logic                       end_of_response,
    output logic                       snap_valid,
    output snap_ctrl_t                 snap_ctrl,
    output logic [1:0][IP_W-1:0]       snap_ip,
    output logic [1:0][FP_W-1:0]       snap_fp,
    output logic [ALT_W-1:0]           snap_alt
);

    localparam int CNT_W     = $clog2(RESP_LIMIT + 1);
    localparam int LEN_W     = $clog2(LINE_LIMIT + 1);
    localparam int FDC_W     = 3;
    localparam int HDR_LEN   = 10;
    localparam int INT_TRY_W = 20;
    localparam int ALT_TRY_W = 27;
    localparam int TERM_W    = 28;

    localparam logic [IP_W-1:0]  IP_MAX  = 17'd99999;
    localparam logic [ALT_W-1:0] ALT_CAP = 24'd9999999;

    localparam logic [3:0] FLD_LAT      = 4'd0;
    localparam logic [3:0] FLD_LAT_HEMI = 4'd1;
    localparam logic [3:0] FLD_LON      = 4'd2;
    localparam logic [3:0] FLD_LON_HEMI = 4'd3;
    localparam logic [3:0] FLD_ALT      = 4'd6;
    localparam logic [3:0] FLD_MAX      = 4'd15;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // Header text, one character per match position.
    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h2B;  // +
            4'd1:    return 8'h43;  // C
            4'd2:    return 8'h47;  // G
            4'd3:    return 8'h50;  // P
            4'd4:    return 8'h53;  // S
            4'd5:    return 8'h49;  // I
            4'd6:    return 8'h4E;  // N
            4'd7:    return 8'h46;  // F
            4'd8:    return 8'h4F;  // O
            4'd9:    return 8'h3A;  // :
            default: return 8'h00;
        endcase
    endfunction

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [3:0]              hdr_reg, hdr_next;
    phase_t                  phase_reg, phase_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [3:0]              fpos_reg, fpos_next;
    logic [1:0][IP_W-1:0]    ip_reg, ip_next;
    logic [1:0][FP_W-1:0]    fp_reg, fp_next;
    logic [FDC_W-1:0]        fdc_reg, fdc_next;
    logic [1:0]              neg_reg, neg_next;
    logic [1:0]              nonempty_reg, nonempty_next;
    logic [ALT_W-1:0]        alt_reg, alt_next;
    logic                    alt_present_reg, alt_present_next;
    logic                    alt_minus_reg, alt_minus_next;
    status_t                 err_reg, err_next;
    num_phase_t              np_reg, np_next;

    logic                    byte_is_digit;
    logic                    byte_is_blank;
    logic                    byte_is_eol;
    logic [3:0]              digit;
    logic                    lane;
    logic [IP_W-1:0]         ip_cur;
    logic [FP_W-1:0]         fp_cur;
    logic [INT_TRY_W-1:0]    int_try;
    logic [FDC_W-1:0]        frac_idx;
    logic [TERM_W-1:0]       frac_term;
    logic [ALT_TRY_W-1:0]    alt_try;
    logic [LEN_W-1:0]        len_inc;
    logic                    field_go;
    status_t                 status;

    // Byte classes and the candidate values of the current field.
    assign byte_is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign byte_is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
    assign byte_is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_NUL);
    assign digit         = rx_byte[3:0];
    assign lane          = fpos_reg[1];
    assign ip_cur        = lane ? ip_reg[1] : ip_reg[0];
    assign fp_cur        = lane ? fp_reg[1] : fp_reg[0];
    assign int_try       = INT_TRY_W'(ip_cur) * INT_TRY_W'(10) + INT_TRY_W'(digit);
    assign frac_idx      = FDC_W'(FRAC_DIGITS - 1) - fdc_reg;
    assign frac_term     = TERM_W'(digit) * TERM_W'(pow10(frac_idx));
    assign alt_try       = (np_reg == NUM_FRAC)
                         ? (ALT_TRY_W'(alt_reg) + ALT_TRY_W'(digit))
                         : (ALT_TRY_W'(alt_reg) * ALT_TRY_W'(10)
                            + ALT_TRY_W'(digit) * ALT_TRY_W'(10));
    assign len_inc       = len_reg + 1'b1;
    assign snap_valid    = accept && end_of_response;

    // Next state for one accepted byte, the snapshot, and the restart.
    always_comb
    begin
        cnt_next         = cnt_reg;
        hdr_next         = hdr_reg;
        phase_next       = phase_reg;
        len_next         = len_reg;
        fpos_next        = fpos_reg;
        ip_next          = ip_reg;
        fp_next          = fp_reg;
        fdc_next         = fdc_reg;
        neg_next         = neg_reg;
        nonempty_next    = nonempty_reg;
        alt_next         = alt_reg;
        alt_present_next = alt_present_reg;
        alt_minus_next   = alt_minus_reg;
        err_next         = err_reg;
        np_next          = np_reg;
        field_go         = 1'b0;
        status           = STAT_OK;

        if (accept && (cnt_reg < CNT_W'(RESP_LIMIT)))
        begin
            cnt_next = cnt_reg + 1'b1;
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (rx_byte == CH_NUL)
                    begin
                        phase_next = PH_DEAD;
                    end
                    else if (rx_byte == hdr_char(hdr_reg))
                    begin
                        hdr_next = hdr_reg + 1'b1;
                        if (hdr_reg == 4'(HDR_LEN - 1))
                        begin
                            phase_next = PH_LEAD;
                            len_next   = LEN_W'(HDR_LEN);
                            if (HDR_LEN >= LINE_LIMIT)
                            begin
                                err_next   = STAT_LINE_LONG;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    else
                    begin
                        hdr_next = (rx_byte == CH_PLUS) ? 4'd1 : 4'd0;
                    end
                end
                PH_LEAD, PH_FIELDS, PH_COUNT:
                begin
                    if (byte_is_eol)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        len_next = len_inc;
                        if (len_inc >= LEN_W'(LINE_LIMIT))
                        begin
                            err_next   = STAT_LINE_LONG;
                            phase_next = PH_DONE;
                        end
                        else if ((phase_reg == PH_LEAD) && (rx_byte == CH_COMMA))
                        begin
                            err_next   = STAT_NO_FIX;
                            phase_next = PH_COUNT;
                        end
                        else if ((phase_reg == PH_LEAD) && !byte_is_blank)
                        begin
                            phase_next = PH_FIELDS;
                            field_go   = 1'b1;
                        end
                        else if (phase_reg == PH_FIELDS)
                        begin
                            field_go = 1'b1;
                        end
                    end
                end
                PH_DONE, PH_DEAD:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // Field content: a comma moves to the next field position.
        if (field_go)
        begin
            if (rx_byte == CH_COMMA)
            begin
                if (fpos_reg != FLD_MAX)
                begin
                    fpos_next = fpos_reg + 1'b1;
                end
                np_next  = NUM_IDLE;
                fdc_next = '0;
            end
            else if ((fpos_reg == FLD_LAT) || (fpos_reg == FLD_LON))
            begin
                nonempty_next[lane] = 1'b1;
                if (np_reg != NUM_END)
                begin
                    if (byte_is_digit)
                    begin
                        if (np_reg == NUM_FRAC)
                        begin
                            // Fraction digits past the kept precision are dropped.
                            if (fdc_reg < FDC_W'(FRAC_DIGITS))
                            begin
                                fp_next[lane] = fp_cur + FP_W'(frac_term);
                                fdc_next      = fdc_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            np_next = NUM_INT;
                            if (int_try > INT_TRY_W'(IP_MAX))
                            begin
                                if (err_reg == STAT_OK)
                                begin
                                    err_next = STAT_OVERLONG;
                                end
                            end
                            else
                            begin
                                ip_next[lane] = IP_W'(int_try);
                            end
                        end
                    end
                    else if (rx_byte == CH_DOT)
                    begin
                        np_next = (np_reg == NUM_FRAC) ? NUM_END : NUM_FRAC;
                    end
                    else if (!(byte_is_blank && (np_reg == NUM_IDLE)))
                    begin
                        np_next = NUM_END;
                    end
                end
            end
            else if ((fpos_reg == FLD_LAT_HEMI) || (fpos_reg == FLD_LON_HEMI))
            begin
                // Only the first character of a hemisphere field counts.
                if (np_reg == NUM_IDLE)
                begin
                    if ((rx_byte == CH_S) || (rx_byte == CH_W))
                    begin
                        neg_next[lane] = 1'b1;
                    end
                    np_next = NUM_END;
                end
            end
            else if (fpos_reg == FLD_ALT)
            begin
                alt_present_next = 1'b1;
                if (np_reg != NUM_END)
                begin
                    if (byte_is_digit)
                    begin
                        // One fraction digit is kept, the value saturates.
                        np_next  = (np_reg == NUM_FRAC) ? NUM_END : NUM_INT;
                        alt_next = (alt_try > ALT_TRY_W'(ALT_CAP)) ? ALT_CAP
                                                                   : ALT_W'(alt_try);
                    end
                    else if (rx_byte == CH_DOT)
                    begin
                        np_next = (np_reg == NUM_FRAC) ? NUM_END : NUM_FRAC;
                    end
                    else if ((np_reg == NUM_IDLE)
                             && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)))
                    begin
                        if (rx_byte == CH_MINUS)
                        begin
                            alt_minus_next = 1'b1;
                        end
                        np_next = NUM_INT;
                    end
                    else if (!(byte_is_blank && (np_reg == NUM_IDLE)))
                    begin
                        np_next = NUM_END;
                    end
                end
            end
        end

        // Status of the response as it stands after this byte.
        if ((phase_next == PH_SEARCH) || (phase_next == PH_DEAD))
        begin
            status = STAT_NO_HEADER;
        end
        else if ((err_next == STAT_LINE_LONG) || (err_next == STAT_NO_FIX))
        begin
            status = err_next;
        end
        else if (fpos_next < FLD_LON_HEMI)
        begin
            // Fewer than four fields.
            status = STAT_FEW_FIELDS;
        end
        else if (!nonempty_next[0] || !nonempty_next[1])
        begin
            status = STAT_EMPTY_COORD;
        end
        else
        begin
            status = err_next;
        end

        snap_ctrl.status      = status;
        snap_ctrl.neg         = neg_next;
        snap_ctrl.alt_present = alt_present_next;
        snap_ctrl.alt_minus   = alt_minus_next;
        snap_ip               = ip_next;
        snap_fp               = fp_next;
        snap_alt              = alt_next;

        // The last byte of a response starts the scanner over.
        if (accept && end_of_response)
        begin
            cnt_next         = '0;
            hdr_next         = '0;
            phase_next       = PH_SEARCH;
            len_next         = '0;
            fpos_next        = '0;
            ip_next          = '0;
            fp_next          = '0;
            fdc_next         = '0;
            neg_next         = '0;
            nonempty_next    = '0;
            alt_next         = '0;
            alt_present_next = 1'b0;
            alt_minus_next   = 1'b0;
            err_next         = STAT_OK;
            np_next          = NUM_IDLE;
        end
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            hdr_reg         <= '0;
            phase_reg       <= PH_SEARCH;
            len_reg         <= '0;
            fpos_reg        <= '0;
            ip_reg          <= '0;
            fp_reg          <= '0;
            fdc_reg         <= '0;
            neg_reg         <= '0;
            nonempty_reg    <= '0;
            alt_reg         <= '0;
            alt_present_reg <= 1'b0;
            alt_minus_reg   <= 1'b0;
            err_reg         <= STAT_OK;
            np_reg          <= NUM_IDLE;
        end
        else
        begin
            cnt_reg         <= cnt_next;
            hdr_reg         <= hdr_next;
            phase_reg       <= phase_next;
            len_reg         <= len_next;
            fpos_reg        <= fpos_next;
            ip_reg          <= ip_next;
            fp_reg          <= fp_next;
            fdc_reg         <= fdc_next;
            neg_reg         <= neg_next;
            nonempty_reg    <= nonempty_next;
            alt_reg         <= alt_next;
            alt_present_reg <= alt_present_next;
            alt_minus_reg   <= alt_minus_next;
            err_reg         <= err_next;
            np_reg          <= np_next;
        end
    end

`ifndef SYNTHESIS
    // While searching, the match position stays inside the header text.
    a_hdr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |-> (hdr_reg < 4'(HDR_LEN)))
        else $error("header match position out of range");

    // The last byte of a response leaves the scanner cleared.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_response) |=> ((phase_reg == PH_SEARCH) && (cnt_reg == '0)))
        else $error("scanner not cleared after end of response");

    // The fraction digit count never passes the kept precision.
    a_fdc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fdc_reg <= FDC_W'(FRAC_DIGITS))
        else $error("fraction digit count overrun");
`endif

endmodule

[sv/gplp_convert.sv]
// ----------------------------------------------------------------------------
// gplp_convert
// Pipeline that turns a finished response into the result item: splits the
// DDMM integer part, scales minutes to 1e-7 degree with rounding, applies the
// signs and holds the result in the output register.
// ----------------------------------------------------------------------------
module gplp_convert
    import gplp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    localparam int FP_W       = $clog2(10 ** FRAC_DIGITS)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        snap_valid,
    output logic                        snap_ready,
    input  snap_ctrl_t                  snap_ctrl,
    input  logic [1:0][IP_W-1:0]        snap_ip,
    input  logic [1:0][FP_W-1:0]        snap_fp,
    input  logic [ALT_W-1:0]            snap_alt,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        fix_valid,
    output logic [2:0]                  parse_status,
    output logic signed [COORD_W-1:0]   latitude_e7,
    output logic signed [COORD_W-1:0]   longitude_e7,
    output logic signed [ALT_OUT_W-1:0] altitude_dm,
    output logic                        altitude_present
);

    localparam int DEG_W        = 10;  // whole degrees, up to 999
    localparam int MIN_W        = 7;   // whole minutes, up to 99
    localparam int DEGE7_W      = 34;  // degrees times 1e7
    localparam int N_W          = 30;  // scaled minutes plus rounding half
    localparam int Q_W          = 24;  // minutes over 60
    localparam int DIV100_MUL_W = 18;
    localparam int DIV100_SHIFT = 24;
    localparam int DIV60_MUL_W  = 31;
    localparam int DIV60_SHIFT  = 36;

    // Reciprocals: exact floor division for all values in range.
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 18'd167773;
    localparam logic [DIV60_MUL_W-1:0]  DIV60_MUL  = 31'd1145324613;
    localparam logic [E7_W-1:0]         E7         = 24'd10000000;
    localparam logic [N_W-1:0]          ROUND_HALF = 30'd30;
    // Fraction units to 1e-7 minutes.
    localparam logic [E7_W-1:0]         FK_MUL     = pow10(3'(7 - FRAC_DIGITS));

    // Stage valid bits and ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r1, r2, r3, r4, r5, r6;

    // Stage 1: snapshot.
    snap_ctrl_t                  ctrl1_reg;
    logic [1:0][IP_W-1:0]        ip1_reg;
    logic [1:0][FP_W-1:0]        fp1_reg;
    logic [ALT_W-1:0]            alt1_reg;
    // Stage 2: degrees split off.
    snap_ctrl_t                  ctrl2_reg;
    logic [1:0][IP_W-1:0]        ip2_reg;
    logic [1:0][FP_W-1:0]        fp2_reg;
    logic [1:0][DEG_W-1:0]       deg2_reg;
    logic [ALT_OUT_W-1:0]        alt2_reg;
    // Stage 3: minutes, scaled fraction and scaled degrees.
    snap_ctrl_t                  ctrl3_reg;
    logic [1:0][MIN_W-1:0]       min3_reg;
    logic [1:0][E7_W-1:0]        fk3_reg;
    logic [1:0][DEGE7_W-1:0]     dege7_3_reg;
    logic [ALT_OUT_W-1:0]        alt3_reg;
    // Stage 4: minutes in 1e-7 units plus half a divisor.
    snap_ctrl_t                  ctrl4_reg;
    logic [1:0][N_W-1:0]         n4_reg;
    logic [1:0][DEGE7_W-1:0]     dege7_4_reg;
    logic [ALT_OUT_W-1:0]        alt4_reg;
    // Stage 5: rounded minutes over 60.
    snap_ctrl_t                  ctrl5_reg;
    logic [1:0][Q_W-1:0]         q5_reg;
    logic [1:0][DEGE7_W-1:0]     dege7_5_reg;
    logic [ALT_OUT_W-1:0]        alt5_reg;
    // Output register.
    logic                        fix_valid_reg;
    status_t                     status_reg;
    logic [COORD_W-1:0]          lat_reg;
    logic [COORD_W-1:0]          lon_reg;
    logic [ALT_OUT_W-1:0]        alt_dm_reg;
    logic                        alt_present_reg;

    logic [1:0][IP_W+DIV100_MUL_W-1:0] deg_prod;
    logic [1:0][IP_W-1:0]              min_diff;
    logic [1:0][N_W+DIV60_MUL_W-1:0]   q_prod;
    logic [1:0][DEGE7_W-1:0]           mag;
    logic [1:0][COORD_W-1:0]           coord;
    logic                              res_ok;

    // A stage loads when it is empty or its content moves on.
    assign r6         = !v6_reg || !result_stall;
    assign r5         = !v5_reg || r6;
    assign r4         = !v4_reg || r5;
    assign r3         = !v3_reg || r4;
    assign r2         = !v2_reg || r3;
    assign r1         = !v1_reg || r2;
    assign snap_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= snap_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // Per-lane arithmetic between the stage registers.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            deg_prod[i] = (IP_W + DIV100_MUL_W)'(ip1_reg[i])
                        * (IP_W + DIV100_MUL_W)'(DIV100_MUL);
            min_diff[i] = ip2_reg[i] - IP_W'(IP_W'(deg2_reg[i]) * IP_W'(100));
            q_prod[i]   = (N_W + DIV60_MUL_W)'(n4_reg[i])
                        * (N_W + DIV60_MUL_W)'(DIV60_MUL);
            mag[i]      = dege7_5_reg[i] + DEGE7_W'(q5_reg[i]);
            coord[i]    = ctrl5_reg.neg[i] ? (COORD_W'(0) - COORD_W'(mag[i]))
                                           : COORD_W'(mag[i]);
        end
    end

    assign res_ok = (ctrl5_reg.status == STAT_OK);

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            ctrl1_reg <= snap_ctrl;
            ip1_reg   <= snap_ip;
            fp1_reg   <= snap_fp;
            alt1_reg  <= snap_alt;
        end
        if (r2)
        begin
            ctrl2_reg <= ctrl1_reg;
            ip2_reg   <= ip1_reg;
            fp2_reg   <= fp1_reg;
            for (int i = 0; i < 2; i++)
            begin
                deg2_reg[i] <= deg_prod[i][DIV100_SHIFT +: DEG_W];
            end
            alt2_reg <= ctrl1_reg.alt_minus ? (ALT_OUT_W'(0) - ALT_OUT_W'(alt1_reg))
                                            : ALT_OUT_W'(alt1_reg);
        end
        if (r3)
        begin
            ctrl3_reg <= ctrl2_reg;
            for (int i = 0; i < 2; i++)
            begin
                min3_reg[i]    <= min_diff[i][MIN_W-1:0];
                fk3_reg[i]     <= E7_W'(E7_W'(fp2_reg[i]) * FK_MUL);
                dege7_3_reg[i] <= DEGE7_W'(deg2_reg[i]) * DEGE7_W'(E7);
            end
            alt3_reg <= alt2_reg;
        end
        if (r4)
        begin
            ctrl4_reg <= ctrl3_reg;
            for (int i = 0; i < 2; i++)
            begin
                n4_reg[i] <= N_W'(min3_reg[i]) * N_W'(E7) + N_W'(fk3_reg[i]) + ROUND_HALF;
            end
            dege7_4_reg <= dege7_3_reg;
            alt4_reg    <= alt3_reg;
        end
        if (r5)
        begin
            ctrl5_reg <= ctrl4_reg;
            for (int i = 0; i < 2; i++)
            begin
                q5_reg[i] <= q_prod[i][DIV60_SHIFT +: Q_W];
            end
            dege7_5_reg <= dege7_4_reg;
            alt5_reg    <= alt4_reg;
        end
        if (r6)
        begin
            fix_valid_reg   <= res_ok;
            status_reg      <= ctrl5_reg.status;
            lat_reg         <= res_ok ? coord[0] : '0;
            lon_reg         <= res_ok ? coord[1] : '0;
            alt_dm_reg      <= (res_ok && ctrl5_reg.alt_present) ? alt5_reg : '0;
            alt_present_reg <= res_ok && ctrl5_reg.alt_present;
        end
    end

    assign result_valid     = v6_reg;
    assign fix_valid        = fix_valid_reg;
    assign parse_status     = status_reg;
    assign latitude_e7      = $signed(lat_reg);
    assign longitude_e7     = $signed(lon_reg);
    assign altitude_dm      = $signed(alt_dm_reg);
    assign altitude_present = alt_present_reg;

`ifndef SYNTHESIS
    // A snapshot is only offered when the first stage can take it.
    a_snap_taken: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |-> snap_ready)
        else $error("snapshot offered while the pipeline is full");

    // The fix flag agrees with the status code.
    a_fix_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fix_valid == (parse_status == STAT_OK)))
        else $error("fix flag and status disagree");

    // A failed parse reports all values as zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !fix_valid) |->
            ((latitude_e7 == '0) && (longitude_e7 == '0)
             && (altitude_dm == '0) && !altitude_present))
        else $error("nonzero values on a failed parse");
`endif

endmodule

[sv/gnss_position_line_parser.sv]
// A result item sits in the output register of the conversion pipeline
// and is held on the outputs until taken. Throughput: one byte item per
// cycle while byte_stall is low; the six-stage conversion pipeline
// lets input continue while up to six results wait on a stalled output.
// Reset: rst_n clears the scanner and all pipeline valid bits at once.
// ----------------------------------------------------------------------------
// gnss_position_line_parser
// Parses the position query answer of a modem byte by byte and gives one
// result item per response: status, latitude and longitude in 1e-7 degree
// and the optional altitude in tenths of a metre.
// ----------------------------------------------------------------------------
module gnss_position_line_parser
    import gplp_pkg::*;
#(
    parameter int RESP_LIMIT  = RESP_LIMIT_DEF,
    parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic [7:0]                  rx_byte,
    input  logic                        end_of_response,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        fix_valid,
    output logic [2:0]                  parse_status,
    output logic signed [COORD_W-1:0]   latitude_e7,
    output logic signed [COORD_W-1:0]   longitude_e7,
    output logic signed [ALT_OUT_W-1:0] altitude_dm,
    output logic                        altitude_present
);

    localparam int FP_W = $clog2(10 ** FRAC_DIGITS);

    logic                    accept;
    logic                    snap_valid;
    logic                    snap_ready;
    snap_ctrl_t              snap_ctrl;
    logic [1:0][IP_W-1:0]    snap_ip;
    logic [1:0][FP_W-1:0]    snap_fp;
    logic [ALT_W-1:0]        snap_alt;

    // Bytes are held off only when the conversion pipeline is full.
    assign byte_stall = !snap_ready;
    assign accept     = byte_valid && !byte_stall;

    gplp_scanner #(
        .RESP_LIMIT  (RESP_LIMIT),
        .LINE_LIMIT  (LINE_LIMIT),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_scanner (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .rx_byte         (rx_byte),
        .end_of_response (end_of_response),
        .snap_valid      (snap_valid),
        .snap_ctrl       (snap_ctrl),
        .snap_ip         (snap_ip),
        .snap_fp         (snap_fp),
        .snap_alt        (snap_alt)
    );

    gplp_convert #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_convert (
        .clk              (clk),
        .rst_n            (rst_n),
        .snap_valid       (snap_valid),
        .snap_ready       (snap_ready),
        .snap_ctrl        (snap_ctrl),
        .snap_ip          (snap_ip),
        .snap_fp          (snap_fp),
        .snap_alt         (snap_alt),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .fix_valid        (fix_valid),
        .parse_status     (parse_status),
        .latitude_e7      (latitude_e7),
        .longitude_e7     (longitude_e7),
        .altitude_dm      (altitude_dm),
        .altitude_present (altitude_present)
    );

endmodule
